// ----- hdl/hmbt_pkg.sv -----
package hmbt_pkg;

  localparam int MAP_SIZE = 1024;
  localparam int BETA_CD  = 2456;
  localparam int GAMMA_CD = 10726;
  localparam int MIN_CELL = 100;

  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_PER_STAGE = 4;
  localparam int CORDIC_STAGES = CORDIC_STEPS / CORDIC_PER_STAGE;

  localparam int QBITS = 18;
  localparam int DIV_PER_STAGE = 3;
  localparam int DIV_STAGES = QBITS / DIV_PER_STAGE;

  localparam logic [1:0] SEC_CENTER = 2'd0;
  localparam logic [1:0] SEC_RIGHT  = 2'd1;
  localparam logic [1:0] SEC_LEFT   = 2'd2;
  localparam logic [1:0] SEC_BEHIND = 2'd3;

  typedef struct packed {
    logic [1:0]          sec;
    logic signed [31:0]  x;
    logic signed [31:0]  y;
    logic signed [23:0]  z;
  } cordic_t;

  typedef struct packed {
    logic [1:0]  sec;
    logic        neg;
    logic [46:0] rem;
    logic [28:0] den;
    logic [17:0] q;
  } div_t;

  typedef struct packed {
    logic [1:0]         sec;
    logic signed [18:0] tan;
  } tan_t;

  function automatic logic signed [23:0] cordic_atan(input int i);
    logic signed [23:0] v;
    case (i)
      0:  v = 24'sd1152000;
      1:  v = 24'sd680065;
      2:  v = 24'sd359328;
      3:  v = 24'sd182400;
      4:  v = 24'sd91554;
      5:  v = 24'sd45822;
      6:  v = 24'sd22916;
      7:  v = 24'sd11459;
      8:  v = 24'sd5730;
      9:  v = 24'sd2865;
      10: v = 24'sd1432;
      11: v = 24'sd716;
      12: v = 24'sd358;
      13: v = 24'sd179;
      14: v = 24'sd90;
      15: v = 24'sd45;
      16: v = 24'sd22;
      17: v = 24'sd11;
      18: v = 24'sd6;
      19: v = 24'sd3;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

  function automatic cordic_t cordic_step(input cordic_t c, input int i);
    cordic_t o;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    o = c;
    dx = c.y >>> i;
    dy = c.x >>> i;
    if (c.z >= 0) begin
      o.x = c.x - dx;
      o.y = c.y + dy;
      o.z = c.z - cordic_atan(i);
    end else begin
      o.x = c.x + dx;
      o.y = c.y - dy;
      o.z = c.z + cordic_atan(i);
    end
    return o;
  endfunction

endpackage

// ----- hdl/hmbt_front.sv -----
module hmbt_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  input  logic signed [15:0]    heading,
  input  logic signed [15:0]    ref_heading,
  output logic                  up_ready,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output hmbt_pkg::cordic_t     dn_data
);
  import hmbt_pkg::*;

  logic              v_r;
  cordic_t           d_r;
  cordic_t           d_nxt;
  logic signed [17:0] diff;
  logic signed [17:0] alpha;
  logic signed [17:0] ang;
  logic              en;

  assign en = !v_r || dn_ready;
  assign up_ready = en;

  always_comb begin
    diff = 18'(ref_heading) - 18'(heading);
    if ((heading > 0 && ref_heading > 0) || (heading < 0 && ref_heading < 0)) begin
      alpha = diff;
    end else if (-diff > 18'sd18000) begin
      alpha = diff + 18'sd36000;
    end else if (diff > 18'sd18000) begin
      alpha = diff - 18'sd36000;
    end else begin
      alpha = diff;
    end
    d_nxt.x = 32'sd268435456;
    d_nxt.y = 32'sd0;
    if (alpha >= -18'(BETA_CD) && alpha <= 18'(BETA_CD)) begin
      d_nxt.sec = SEC_CENTER;
      ang = alpha;
    end else if (alpha > 18'(BETA_CD) && alpha <= 18'(GAMMA_CD)) begin
      d_nxt.sec = SEC_RIGHT;
      ang = 18'sd9000 - alpha;
    end else if (alpha < -18'(BETA_CD) && alpha >= -18'(GAMMA_CD)) begin
      d_nxt.sec = SEC_LEFT;
      ang = 18'sd9000 + alpha;
    end else begin
      d_nxt.sec = SEC_BEHIND;
      ang = 18'sd0;
    end
    d_nxt.z = {ang[15:0], 8'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
    if (en && up_valid) begin
      d_r <= d_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data = d_r;

endmodule

// ----- hdl/hmbt_cordic.sv -----
module hmbt_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  hmbt_pkg::cordic_t  up_data,
  output logic               up_ready,
  output logic               dn_valid,
  input  logic               dn_ready,
  output hmbt_pkg::div_t     dn_data
);
  import hmbt_pkg::*;

  logic    v_r [CORDIC_STAGES];
  cordic_t d_r [CORDIC_STAGES];
  cordic_t d_nxt [CORDIC_STAGES];
  logic    en [CORDIC_STAGES+1];

  always_comb begin
    en[CORDIC_STAGES] = dn_ready;
    for (int s = CORDIC_STAGES - 1; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end
  assign up_ready = en[0];

  always_comb begin
    for (int s = 0; s < CORDIC_STAGES; s++) begin
      d_nxt[s] = (s == 0) ? up_data : d_r[(s == 0) ? 0 : s - 1];
      for (int k = 0; k < CORDIC_PER_STAGE; k++) begin
        d_nxt[s] = cordic_step(d_nxt[s], s * CORDIC_PER_STAGE + k);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < CORDIC_STAGES; s++) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en[s]) begin
        v_r[s] <= (s == 0) ? up_valid : v_r[(s == 0) ? 0 : s - 1];
      end
      if (en[s]) begin
        d_r[s] <= d_nxt[s];
      end
    end
  end

  logic [28:0] mag;
  cordic_t     last;
  assign last = d_r[CORDIC_STAGES-1];
  assign mag = last.y[31] ? 29'(-last.y) : last.y[28:0];

  assign dn_valid = v_r[CORDIC_STAGES-1];
  always_comb begin
    dn_data.sec = last.sec;
    dn_data.neg = last.y[31];
    dn_data.rem = {2'b00, mag, 16'd0};
    dn_data.den = last.x[28:0];
    dn_data.q   = '0;
  end

endmodule

// ----- hdl/hmbt_div.sv -----
module hmbt_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  input  hmbt_pkg::div_t   up_data,
  output logic             up_ready,
  output logic             dn_valid,
  input  logic             dn_ready,
  output hmbt_pkg::tan_t   dn_data
);
  import hmbt_pkg::*;

  logic v_r [DIV_STAGES];
  div_t d_r [DIV_STAGES];
  div_t d_nxt [DIV_STAGES];
  logic en [DIV_STAGES+1];

  always_comb begin
    en[DIV_STAGES] = dn_ready;
    for (int s = DIV_STAGES - 1; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end
  assign up_ready = en[0];

  // restoring division, one quotient bit per step, MSB first
  always_comb begin
    logic [46:0] sub;
    int          b;
    for (int s = 0; s < DIV_STAGES; s++) begin
      d_nxt[s] = (s == 0) ? up_data : d_r[(s == 0) ? 0 : s - 1];
      for (int k = 0; k < DIV_PER_STAGE; k++) begin
        b = QBITS - 1 - s * DIV_PER_STAGE - k;
        sub = 47'(d_nxt[s].den) << b;
        if (d_nxt[s].rem >= sub) begin
          d_nxt[s].rem = d_nxt[s].rem - sub;
          d_nxt[s].q[b] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en[s]) begin
        v_r[s] <= (s == 0) ? up_valid : v_r[(s == 0) ? 0 : s - 1];
      end
      if (en[s]) begin
        d_r[s] <= d_nxt[s];
      end
    end
  end

  div_t last;
  assign last = d_r[DIV_STAGES-1];
  assign dn_valid = v_r[DIV_STAGES-1];
  assign dn_data.sec = last.sec;
  assign dn_data.tan = last.neg ? -$signed({1'b0, last.q}) : $signed({1'b0, last.q});

endmodule

// ----- hdl/hmbt_back.sv -----
module hmbt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  input  hmbt_pkg::tan_t   up_data,
  output logic             up_ready,
  output logic             dn_valid,
  input  logic             dn_stall,
  output logic [11:0]      target_x,
  output logic [11:0]      target_y
);
  import hmbt_pkg::*;

  localparam logic [17:0] X_CENTER = 18'(MAP_SIZE / 2);
  localparam logic [17:0] X_RIGHT  = 18'((9 * MAP_SIZE) / 10);
  localparam logic [17:0] X_LEFT   = 18'(MAP_SIZE / 10);
  localparam logic [17:0] Y_CENTER = 18'((39 * MAP_SIZE) / 40);
  localparam logic [17:0] Y_BEHIND = 18'(MAP_SIZE / 10);
  localparam logic [17:0] MIN_C    = 18'(MIN_CELL);

  logic               v1_r, v2_r, v3_r;
  logic               en1, en2, en3;
  logic [1:0]         sec1_r, sec2_r;
  logic signed [35:0] p1_r;
  logic signed [35:0] p1_nxt;
  logic [17:0]        cx2_r;
  logic               neg2_r;
  logic [31:0]        q2_r;
  logic [17:0]        ty_raw;
  logic [17:0]        x_nxt, y_nxt;
  logic [11:0]        tx_r, ty_r;
  logic signed [20:0] tc;
  logic signed [20:0] ts;

  assign en3 = !v3_r || !dn_stall;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign up_ready = en1;

  always_comb begin
    tc = 21'(up_data.tan) * 21'sd7 + 21'sd262144;
    ts = 21'(up_data.tan) * 21'sd4 + 21'sd65536;
    if (up_data.sec == SEC_CENTER) begin
      p1_nxt = 36'(tc) * 36'(MAP_SIZE);
    end else begin
      p1_nxt = 36'(ts) * 36'(MAP_SIZE);
    end
  end

  always_comb begin
    ty_raw = neg2_r ? 18'd0 : 18'(q2_r >> 19);
    case (sec2_r)
      SEC_CENTER: begin
        x_nxt = cx2_r;
        y_nxt = Y_CENTER;
      end
      SEC_RIGHT: begin
        x_nxt = X_RIGHT;
        y_nxt = ty_raw;
      end
      SEC_LEFT: begin
        x_nxt = X_LEFT;
        y_nxt = ty_raw;
      end
      default: begin
        x_nxt = X_CENTER;
        y_nxt = Y_BEHIND;
      end
    endcase
    if (x_nxt < MIN_C) x_nxt = MIN_C;
    if (y_nxt < MIN_C) y_nxt = MIN_C;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
    if (en1) begin
      sec1_r <= up_data.sec;
      p1_r   <= p1_nxt;
    end
    if (en2) begin
      sec2_r <= sec1_r;
      cx2_r  <= 18'(p1_r >>> 19);
      neg2_r <= p1_r[35];
      // divide by ten: multiply by the 16-bit reciprocal, shift in the next stage
      q2_r   <= 32'(p1_r[31:16]) * 32'd52429;
    end
    if (en3) begin
      tx_r <= x_nxt[11:0];
      ty_r <= y_nxt[11:0];
    end
  end

  assign dn_valid = v3_r;
  assign target_x = tx_r;
  assign target_y = ty_r;

endmodule

// ----- hdl/heading_to_map_border_target.sv -----
// Stages: 1 front stage, 5 CORDIC stages of 4 rotations, 6 divider stages of
// 3 quotient bits, 3 output stages. Throughput: one item per cycle while out_stall
// is low; a full stage holds only while the stage after it holds.
// Reset (rst_n low, synchronous) empties every stage and sets ref_heading to 0.
module heading_to_map_border_target (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        out_target_x,
  output logic [11:0]        out_target_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [15:0] cfg_ref_heading
);
  import hmbt_pkg::*;

  logic signed [15:0] ref_r;
  logic    f_rdy, c_rdy, d_rdy, b_rdy;
  logic    f_v, c_v, d_v;
  cordic_t f_data;
  div_t    c_data;
  tan_t    d_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= '0;
    end else if (cfg_valid) begin
      ref_r <= cfg_ref_heading;
    end
  end

  assign in_stall = !f_rdy;

  hmbt_front u_front (
    .clk, .rst_n,
    .up_valid(in_valid), .heading(in_heading), .ref_heading(ref_r),
    .up_ready(f_rdy), .dn_valid(f_v), .dn_ready(c_rdy), .dn_data(f_data)
  );

  hmbt_cordic u_cordic (
    .clk, .rst_n,
    .up_valid(f_v), .up_data(f_data), .up_ready(c_rdy),
    .dn_valid(c_v), .dn_ready(d_rdy), .dn_data(c_data)
  );

  hmbt_div u_div (
    .clk, .rst_n,
    .up_valid(c_v), .up_data(c_data), .up_ready(d_rdy),
    .dn_valid(d_v), .dn_ready(b_rdy), .dn_data(d_data)
  );

  hmbt_back u_back (
    .clk, .rst_n,
    .up_valid(d_v), .up_data(d_data), .up_ready(b_rdy),
    .dn_valid(out_valid), .dn_stall(out_stall),
    .target_x(out_target_x), .target_y(out_target_y)
  );

endmodule
